FILE: hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned CFG_W    = 12;
  localparam int unsigned REQ_W    = 12;
  localparam int unsigned PW_W     = 10;
  localparam int unsigned NEED_W   = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 12'd4092;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_ALLOC   = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_FREED   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S_RD,
    ST_S_EVAL,
    ST_SPLIT,
    ST_M_RD,
    ST_M_LD,
    ST_M_TEST,
    ST_M_NX,
    ST_F_RD,
    ST_F_EVAL,
    ST_RESP
  } state_t;

endpackage

FILE: hw/rtl/ffha_if.sv
// Request and result channel interfaces of the first-fit heap allocator.
interface ffha_req_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [REQ_W-1:0]  request_bytes;
  logic [PW_W-1:0]   payload_word;

  modport source (output valid, opcode, request_bytes, payload_word, input ready);
  modport sink   (input valid, opcode, request_bytes, payload_word, output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [PW_W-1:0]  granted_word;

  modport source (output valid, status, granted_word, input ready);
  modport sink   (input valid, status, granted_word, output ready);
endinterface

FILE: hw/rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over an implicit list of block headers held in one RAM.
//
// Every header access goes through a single-port RAM with a registered read,
// so each step of the sequencer costs one RAM access. A free reads its header
// and evaluates it, or goes straight to its response when the header lies outside
// the heap. An allocate walks the header chain, reading and evaluating each header;
// when no block fits it runs a merging pass (read, load and test per header visited,
// a read of the following header when a free header has one, and a write and a
// new test per merge) and walks once more. After reset and after every
// configuration write the heap is formatted by a clearing sweep of one word per
// cycle over the heap (up to 1024 words by default); no item is accepted then.
// A result waits in an output register, and the next item may be accepted while
// it is still unread.
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_WORDS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ffha_req_if.sink                  in_if,
  ffha_rsp_if.source                out_if,
  input  logic                      cfg_we,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_wdata
);
  import ffha_pkg::*;

  localparam int unsigned AW  = $clog2(HEAP_WORDS);
  localparam int unsigned EW  = AW + 1;
  localparam int unsigned DW  = AW + 3;
  localparam int unsigned CW  = (DW > NEED_W) ? DW : NEED_W;
  localparam int unsigned GW  = (EW > PW_W) ? EW : PW_W;
  localparam int unsigned CAP = HEAP_WORDS - (HEAP_WORDS % 2);

  // Heap length in words for a requested byte count, capped to the RAM.
  function automatic logic [EW-1:0] heap_words_f(input logic [CFG_W-1:0] req);
    logic [CFG_W:0]   sum;
    logic [CFG_W-2:0] units;
    logic [CFG_W-1:0] words;
    sum   = {1'b0, req} + (CFG_W+1)'(3);
    units = {1'b0, sum[CFG_W:3]} + (CFG_W-1)'(1);
    words = {units, 1'b0};
    if (32'(words) > CAP) begin
      return EW'(CAP);
    end
    return EW'(words);
  endfunction

  // Next header index, or the heap end when the chain is broken.
  function automatic logic [EW-1:0] next_f(input logic [EW-1:0] h,
                                           input logic [DW-1:0] hv,
                                           input logic [EW-1:0] hend);
    logic [EW-1:0] step;
    logic [EW-1:0] room;
    step = hv[DW-1:2];
    room = hend - h;
    if (step == '0 || step > room) begin
      return hend;
    end
    return h + step;
  endfunction

  logic [DW-1:0] mem [HEAP_WORDS];
  logic [DW-1:0] mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata;

  state_t            state_r, state_nxt;
  logic [EW-1:0]     end_r, end_nxt;
  logic [EW-1:0]     clr_r, clr_nxt;
  logic [EW-1:0]     h_r, h_nxt;
  logic [EW-1:0]     nx_r, nx_nxt;
  logic [DW-1:0]     hv_r, hv_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic              pass_r, pass_nxt;
  logic [EW-1:0]     split_r, split_nxt;
  logic [DW-1:0]     rest_r, rest_nxt;
  status_t           status_r, status_nxt;
  logic [PW_W-1:0]   granted_r, granted_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [PW_W-1:0]   out_granted_r, out_granted_nxt;

  logic [DW-1:0]     sv_size;
  logic [EW-1:0]     sv_step;
  logic [EW-1:0]     sv_room;
  logic              sv_fit;
  logic [EW-1:0]     mt_nx;
  logic [DW-1:0]     mx_sum;
  logic [CFG_W:0]    rq_sum;
  logic [CFG_W-2:0]  rq_units;
  logic [GW-1:0]     fr_h;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  always_comb begin
    sv_size = {mem_rdata_r[DW-1:2], 2'b00};
    sv_step = mem_rdata_r[DW-1:2];
    sv_room = end_r - h_r;
    sv_fit  = !mem_rdata_r[0] && (CW'(need_r) <= CW'(sv_size)) &&
              (sv_step != '0) && (sv_step <= sv_room);
    mt_nx   = next_f(h_r, hv_r, end_r);
    mx_sum  = {hv_r[DW-1:2], 2'b00} + {mem_rdata_r[DW-1:2], 2'b00};
    rq_sum   = {1'b0, in_if.request_bytes} + (CFG_W+1)'(3);
    rq_units = {1'b0, rq_sum[CFG_W:3]} + (CFG_W-1)'(1);
    fr_h     = GW'(in_if.payload_word) - GW'(1);
  end

  always_comb begin
    state_nxt       = state_r;
    end_nxt         = end_r;
    clr_nxt         = clr_r;
    h_nxt           = h_r;
    nx_nxt          = nx_r;
    hv_nxt          = hv_r;
    need_nxt        = need_r;
    pass_nxt        = pass_r;
    split_nxt       = split_r;
    rest_nxt        = rest_r;
    status_nxt      = status_r;
    granted_nxt     = granted_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    mem_we          = 1'b0;
    mem_addr        = h_r[AW-1:0];
    mem_wdata       = '0;
    in_if.ready     = (state_r == ST_IDLE);

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r[AW-1:0];
        mem_wdata = (clr_r == '0) ? {end_r, 2'b00} : '0;
        clr_nxt   = clr_r + EW'(1);
        if (clr_nxt == end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          granted_nxt = '0;
          if (in_if.opcode == OP_ALLOC) begin
            need_nxt  = NEED_W'({rq_units, 3'b000});
            h_nxt     = '0;
            pass_nxt  = 1'b0;
            state_nxt = ST_S_RD;
          end else if (in_if.payload_word != '0 && fr_h < GW'(end_r)) begin
            h_nxt     = EW'(fr_h);
            state_nxt = ST_F_RD;
          end else begin
            status_nxt = STAT_IGNORED;
            state_nxt  = ST_RESP;
          end
        end
      end
      ST_S_RD: begin
        if (h_r >= end_r) begin
          if (!pass_r) begin
            h_nxt     = '0;
            state_nxt = ST_M_RD;
          end else begin
            status_nxt = STAT_NOSPACE;
            state_nxt  = ST_RESP;
          end
        end else begin
          state_nxt = ST_S_EVAL;
        end
      end
      ST_S_EVAL: begin
        if (sv_fit) begin
          mem_we      = 1'b1;
          mem_wdata   = DW'(need_r) | DW'(1);
          rest_nxt    = sv_size - DW'(need_r);
          split_nxt   = h_r + EW'(need_r >> 2);
          status_nxt  = STAT_ALLOC;
          granted_nxt = PW_W'(GW'(h_r) + GW'(1));
          // An exact fit leaves no remainder block to describe.
          state_nxt   = (rest_nxt != '0) ? ST_SPLIT : ST_RESP;
        end else begin
          h_nxt     = next_f(h_r, mem_rdata_r, end_r);
          state_nxt = ST_S_RD;
        end
      end
      ST_SPLIT: begin
        mem_we    = 1'b1;
        mem_addr  = split_r[AW-1:0];
        mem_wdata = rest_r;
        state_nxt = ST_RESP;
      end
      ST_M_RD: begin
        if (h_r >= end_r) begin
          h_nxt     = '0;
          pass_nxt  = 1'b1;
          state_nxt = ST_S_RD;
        end else begin
          state_nxt = ST_M_LD;
        end
      end
      ST_M_LD: begin
        hv_nxt    = mem_rdata_r;
        state_nxt = ST_M_TEST;
      end
      ST_M_TEST: begin
        nx_nxt = mt_nx;
        if (!hv_r[0] && mt_nx < end_r) begin
          mem_addr  = mt_nx[AW-1:0];
          state_nxt = ST_M_NX;
        end else begin
          h_nxt     = mt_nx;
          state_nxt = ST_M_RD;
        end
      end
      ST_M_NX: begin
        // Absorb a free neighbor and test the grown block again.
        if (!mem_rdata_r[0] && mem_rdata_r[DW-1:2] != '0) begin
          mem_we    = 1'b1;
          mem_wdata = mx_sum;
          hv_nxt    = mx_sum;
          state_nxt = ST_M_TEST;
        end else begin
          h_nxt     = nx_r;
          state_nxt = ST_M_RD;
        end
      end
      ST_F_RD: begin
        state_nxt = ST_F_EVAL;
      end
      ST_F_EVAL: begin
        if (mem_rdata_r[0]) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata_r & ~DW'(1);
          status_nxt = STAT_FREED;
        end else begin
          status_nxt = STAT_IGNORED;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new heap size reformats the heap from scratch.
    if (cfg_we) begin
      end_nxt   = heap_words_f(cfg_wdata);
      clr_nxt   = '0;
      state_nxt = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      end_r       <= heap_words_f(CFG_RESET);
      clr_r       <= '0;
      h_r         <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      end_r       <= end_nxt;
      clr_r       <= clr_nxt;
      h_r         <= h_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nx_r          <= nx_nxt;
    hv_r          <= hv_nxt;
    need_r        <= need_nxt;
    split_r       <= split_nxt;
    rest_r        <= rest_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.granted_word = out_granted_r;

  a_granted_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status != STAT_ALLOC |-> out_if.granted_word == '0)
    else $error("granted word set on a result that is not an allocation");

  a_walk_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && state_r != ST_CLEAR && state_r != ST_RESP |-> h_r <= end_r)
    else $error("header walk left the heap");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> EW'(mem_addr) < end_r)
    else $error("heap write beyond the heap end");

  a_cfg_reformats: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> state_r == ST_CLEAR && clr_r == '0)
    else $error("configuration write did not start a format sweep");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESP && out_valid_r && !out_if.ready |=> state_r == ST_RESP)
    else $error("result dropped while the output register was full");

endmodule

FILE: tb/ffha_checker.sv
// Checker for the first-fit heap allocator: tracks the heap headers and compares every result.
module ffha_checker #(
  parameter int unsigned HEAP_WORDS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ffha_req_if                        in_ch,
  ffha_rsp_if                        out_ch,
  input  logic                       cfg_we,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       run_done,
  output int unsigned                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  typedef struct packed {
    status_t         status;
    logic [PW_W-1:0] granted;
  } heap_result_t;

  logic [15:0]  hdr_mem [HEAP_WORDS];
  logic [31:0]  end_words;
  heap_result_t pending_results [$];
  heap_result_t want;
  bit           leftovers_checked;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Formatting leaves one free block that covers the whole heap.
  function automatic void format_heap(input logic [CFG_W-1:0] heap_bytes);
    logic [31:0] words;
    logic [31:0] cap;
    logic [31:0] hdr;
    words = (({20'd0, heap_bytes} + 32'd3) / 32'd8 + 32'd1) * 32'd2;
    cap = (HEAP_WORDS / 2) * 2;
    if (words > cap) words = cap;
    for (int i = 0; i < HEAP_WORDS; i++) hdr_mem[i] = '0;
    end_words = words;
    hdr = words << 2;
    if (words != 0) hdr_mem[0] = hdr[15:0];
  endfunction

  // A zero step or one that overshoots the heap end breaks the chain.
  function automatic logic [31:0] next_hdr(input logic [31:0] h);
    logic [31:0] step;
    step = {18'd0, hdr_mem[h][15:2]};
    if (step == 0 || step > end_words - h) return end_words;
    return h + step;
  endfunction

  function automatic logic [31:0] find_fit(input logic [31:0] need);
    logic [31:0] h;
    logic [31:0] size;
    logic [31:0] nx;
    logic [31:0] rest;
    h = 0;
    while (h < end_words) begin
      size = {16'd0, hdr_mem[h][15:2], 2'b00};
      nx = next_hdr(h);
      if (!hdr_mem[h][0] && need <= size && size != 0 && size / 4 <= end_words - h) begin
        rest = size - need;
        hdr_mem[h] = need[15:0] | 16'd1;
        // An exact fit leaves no remainder block behind.
        if (rest != 0 && h + need / 4 < end_words) hdr_mem[h + need / 4] = rest[15:0];
        return h + 1;
      end
      h = nx;
    end
    return 0;
  endfunction

  function automatic void merge_runs();
    logic [31:0] h;
    logic [31:0] nx;
    h = 0;
    while (h < end_words) begin
      nx = next_hdr(h);
      if (!hdr_mem[h][0] && nx < end_words && !hdr_mem[nx][0] && hdr_mem[h][15:2] != 0 &&
          hdr_mem[nx][15:2] != 0) begin
        hdr_mem[h] = {hdr_mem[h][15:2] + hdr_mem[nx][15:2], 2'b00};
      end else begin
        h = nx;
      end
    end
  endfunction

  function automatic heap_result_t allocator_response(input logic opc,
                                                      input logic [REQ_W-1:0] nbytes,
                                                      input logic [PW_W-1:0] word);
    heap_result_t r;
    logic [31:0]  need;
    logic [31:0]  g;
    logic [31:0]  h;
    r.status = STAT_ALLOC;
    r.granted = '0;
    if (opc == OP_ALLOC) begin
      need = (({20'd0, nbytes} + 32'd3) / 32'd8 + 32'd1) * 32'd8;
      g = find_fit(need);
      if (g == 0) begin
        merge_runs();
        g = find_fit(need);
      end
      r.status = (g != 0) ? STAT_ALLOC : STAT_NOSPACE;
      r.granted = g[PW_W-1:0];
    end else begin
      h = {22'd0, word} - 32'd1;
      if (word != 0 && h < end_words && hdr_mem[h][0]) begin
        hdr_mem[h][0] = 1'b0;
        r.status = STAT_FREED;
      end else begin
        r.status = STAT_IGNORED;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      format_heap(CFG_RESET);
      pending_results.delete();
      fail_count = 0;
      leftovers_checked = 1'b0;
    end else begin
      if (cfg_we) format_heap(cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(allocator_response(in_ch.opcode, in_ch.request_bytes,
                                                     in_ch.payload_word));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: status %0d word %0d",
                                  out_ch.status, out_ch.granted_word));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
          end
          if (out_ch.granted_word !== want.granted) begin
            flag_mismatch($sformatf("granted word %0d, expected %0d",
                                    out_ch.granted_word, want.granted));
          end
        end
      end
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (pending_results.size() != 0) begin
          flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
// Top of the heap allocator testbench: clock, reset, stimulus phases and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic             req_opcode = OP_ALLOC;
  logic [REQ_W-1:0] req_bytes = '0;
  logic [PW_W-1:0]  req_word = '0;
  logic             rsp_ready = 1'b0;
  logic             run_done = 1'b0;
  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_done = 0;
  int unsigned      checker_fails;
  logic [PW_W-1:0]  live_words [$];
  logic [PW_W-1:0]  last_freed = '0;

  ffha_req_if in_ch ();
  ffha_rsp_if out_ch ();

  assign in_ch.valid         = req_valid;
  assign in_ch.opcode        = req_opcode;
  assign in_ch.request_bytes = req_bytes;
  assign in_ch.payload_word  = req_word;
  assign out_ch.ready        = rsp_ready;

  first_fit_heap_allocator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ffha_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .run_done   (run_done),
    .fail_count (checker_fails)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Sampled mid-cycle, so this sees the handshake of the coming rising edge.
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && rsp_ready) begin
      n_done++;
      if (out_ch.status == STAT_ALLOC) live_words.push_back(out_ch.granted_word);
    end
  end

  task automatic send_op(input logic opc, input logic [REQ_W-1:0] nbytes,
                         input logic [PW_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_opcode <= opc;
    req_bytes  <= nbytes;
    req_word   <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (n_done != n_sent) @(posedge clk);
  endtask

  task automatic write_heap_size(input logic [CFG_W-1:0] heap_bytes);
    cfg_wdata <= heap_bytes;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_words.delete();
  endtask

  // Mostly allocations and frees of live blocks, with stray and repeated frees mixed in.
  task automatic run_phase(input logic [CFG_W-1:0] heap_bytes, input int unsigned idle,
                           input int unsigned stall, input int unsigned count,
                           input bit hold_mid);
    int unsigned pick;
    int          idx;
    logic [31:0] rnd;
    logic [31:0] sz;
    logic [PW_W-1:0] w;
    wait_drained();
    write_heap_size(heap_bytes);
    idle_pct = idle;
    stall_pct <= stall;
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) begin
        req_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      pick = $urandom_range(99);
      rnd = $urandom;
      if (pick < 50 || (pick < 85 && live_words.size() == 0)) begin
        if ($urandom_range(99) < 70) sz = $urandom_range(120);
        else if ($urandom_range(99) < 67) sz = $urandom_range(1000);
        else sz = $urandom_range(4092);
        send_op(OP_ALLOC, sz[REQ_W-1:0], rnd[PW_W-1:0]);
      end else begin
        if (pick < 85) begin
          idx = $urandom_range(live_words.size() - 1);
          w = live_words[idx];
          live_words.delete(idx);
          last_freed = w;
        end else if (pick < 93) begin
          sz = $urandom_range(1023, 1);
          w = sz[PW_W-1:0];
        end else begin
          w = last_freed;
        end
        sz = $urandom_range(4092);
        send_op(OP_FREE, sz[REQ_W-1:0], w);
      end
    end
    req_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items on the heap as formatted at reset.
    send_op(OP_ALLOC, 12'd0, 10'd0);
    send_op(OP_ALLOC, 12'd4092, 10'd1023);  // needs the whole heap: no space even after merging
    send_op(OP_FREE, 12'd4092, 10'd1);
    send_op(OP_FREE, 12'd0, 10'd1);         // double free is ignored
    send_op(OP_FREE, 12'd0, 10'd0);         // payload word zero lies outside the heap
    send_op(OP_FREE, 12'd0, 10'd1023);
    send_op(OP_ALLOC, 12'd4092, 10'd0);     // merges the two free blocks, then fits exactly
    send_op(OP_ALLOC, 12'd4, 10'd0);
    send_op(OP_FREE, 12'd0, 10'd1);
    send_op(OP_ALLOC, 12'd12, 10'd0);
    send_op(OP_ALLOC, 12'd5, 10'd0);
    send_op(OP_ALLOC, 12'd100, 10'd0);
    send_op(OP_ALLOC, 12'd4092, 10'd0);
    send_op(OP_FREE, 12'd0, 10'd3);         // interior word of a block, not a header
    send_op(OP_FREE, 12'd0, 10'd5);
    send_op(OP_ALLOC, 12'd3, 10'd0);
    send_op(OP_FREE, 12'd0, 10'd1);
    send_op(OP_FREE, 12'd0, 10'd5);
    send_op(OP_ALLOC, 12'd2048, 10'd0);
    req_valid <= 1'b0;

    run_phase(12'd0, 0, 0, 20, 1'b0);
    run_phase(12'd4095, 54, 0, 60, 1'b0);   // larger than the heap array, so it gets cut down
    run_phase(12'd300, 0, 54, 50, 1'b0);
    run_phase(12'd1000, 19, 19, 60, 1'b1);
    run_phase(12'd4092, 0, 0, 60, 1'b0);
    run_phase(12'd128, 19, 19, 40, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (checker_fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
